// ===== design/scs_pkg.sv =====
// Shared types, command codes and controller/datapath interface for the channel sequencer.
package scs_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned RAND_W = 15;
    localparam int unsigned CHAN_W = 5;
    localparam int unsigned SIZE_W = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SWAP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RAND_W-1:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic              fire;
        logic [CHAN_W-1:0] channel;
        logic              shuffle_busy;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_SUB,
        S_RDR,
        S_WRA,
        S_WRR,
        S_TRIG,
        S_PLAY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic mul;
        logic sub;
        logic rd_a;
        logic rd_r;
        logic wr_a;
        logic wr_r;
        logic trig_arm;
        logic rd_play;
        logic play_fire;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic swap_active;
        logic parity;
    } t_dp_status;

endpackage

// ===== design/scs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/scs_ctrl.sv =====
// Sequencer controller: state machine and output valid flag.
module scs_ctrl
    import scs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  logic             i_out_stall,
    input  t_dp_status       i_status,
    output t_ctrl_cmd        o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_START:   n_state = S_START;
                        CMD_SWAP:    n_state = i_status.swap_active ? S_MUL : S_DONE;
                        CMD_TRIGGER: n_state = S_TRIG;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_START: n_state = S_DONE;
            S_MUL:   n_state = S_SUB;
            S_SUB:   n_state = S_RDR;
            S_RDR:   n_state = S_WRA;
            S_WRA:   n_state = S_WRR;
            S_WRR:   n_state = S_DONE;
            S_TRIG:  n_state = i_status.parity ? S_PLAY : S_DONE;
            S_PLAY:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.accept    = i_in_valid;
            S_START: o_cmd.start     = 1'b1;
            S_MUL:   o_cmd.mul       = 1'b1;
            S_SUB: begin
                o_cmd.sub  = 1'b1;
                o_cmd.rd_a = 1'b1;
            end
            S_RDR:   o_cmd.rd_r      = 1'b1;
            S_WRA:   o_cmd.wr_a      = 1'b1;
            S_WRR:   o_cmd.wr_r      = 1'b1;
            S_TRIG: begin
                o_cmd.trig_arm = !i_status.parity;
                o_cmd.rd_play  = i_status.parity;
            end
            S_PLAY:  o_cmd.play_fire = 1'b1;
            S_DONE:  o_cmd.load_out  = !r_out_valid || !i_out_stall;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_mul_only_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> i_status.swap_active)
        else $error("swap arithmetic started with no swap pending");

    a_play_needs_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLAY) |-> i_status.parity)
        else $error("channel fired on an even pulse");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside the completion state");

endmodule

// ===== design/scs_dp.sv =====
// Sequencer datapath: order table, swap arithmetic, play state and result register.
module scs_dp
    import scs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    output t_out_item         o_out
);

    localparam int unsigned IW    = $clog2(TABLE_DEPTH);
    localparam int unsigned EW    = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned DW    = IW + 1;
    localparam int unsigned SHIFT = RAND_W + IW;
    localparam int unsigned MW    = SHIFT + 1;
    localparam int unsigned PW    = RAND_W + MW;
    localparam int unsigned QW    = RAND_W + DW;
    localparam int unsigned CW    = (IW + 1 > SIZE_W) ? IW + 1 : SIZE_W;

    // ceil(2^SHIFT / (a+1)) for every swap index a: exact quotient for 15-bit words
    logic [MW-1:0] c_recip [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_recip
        localparam longint unsigned RC =
            ((longint'(1) << SHIFT) + longint'(g)) / longint'(g + 1);
        assign c_recip[g] = MW'(RC);
    end

    logic [SIZE_W-1:0]      r_size;
    logic [IW-1:0]          r_swap_index;
    logic [IW-1:0]          n_swap_index;
    logic [IW-1:0]          r_play_ptr;
    logic                   r_parity;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_rd_valid;

    logic [RAND_W-1:0]      r_rnd;
    logic [RAND_W-1:0]      r_quot;
    logic [IW-1:0]          r_slot;
    logic [IW-1:0]          r_rd_addr;
    logic [EW-1:0]          r_val_a;
    logic                   r_fire;
    logic [EW-1:0]          r_chan;
    t_out_item              r_out;

    logic [PW-1:0]          prod;
    logic [DW-1:0]          divisor;
    logic [QW-1:0]          qd;
    logic [RAND_W-1:0]      rem;
    logic [CW-1:0]          size_ext;
    logic [CW-1:0]          size_sat;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [IW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;
    logic [EW-1:0]          rd_data;

    assign prod    = PW'(r_rnd) * PW'(c_recip[r_swap_index]);
    assign divisor = DW'(r_swap_index) + DW'(1);
    assign qd      = QW'(r_quot) * QW'(divisor);
    assign rem     = r_rnd - qd[RAND_W-1:0];

    assign size_ext = CW'(r_size);
    assign size_sat = (size_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : size_ext;

    always_comb begin
        n_swap_index = r_swap_index;
        if (i_cmd.start) begin
            n_swap_index = (size_sat == '0) ? '0 : IW'(size_sat - CW'(1));
        end else if (i_cmd.wr_r) begin
            n_swap_index = r_swap_index - IW'(1);
        end
    end

    // entries never written since reset or start read as the identity
    assign rd_data = r_rd_valid ? ram_rdata : (EW'(r_rd_addr) + EW'(1));

    always_comb begin
        ram_re    = i_cmd.rd_a || i_cmd.rd_r || i_cmd.rd_play;
        ram_raddr = r_play_ptr;
        if (i_cmd.rd_a) begin
            ram_raddr = r_swap_index;
        end else if (i_cmd.rd_r) begin
            ram_raddr = r_slot;
        end
        ram_we    = i_cmd.wr_a || i_cmd.wr_r;
        ram_waddr = i_cmd.wr_a ? r_swap_index : r_slot;
        ram_wdata = i_cmd.wr_a ? rd_data : r_val_a;
    end

    scs_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= SIZE_RESET;
            r_swap_index <= '0;
            r_play_ptr   <= '0;
            r_parity     <= 1'b0;
            r_valid      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_swap_index <= n_swap_index;
            if (i_cmd.start) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cmd.trig_arm) begin
                r_parity <= 1'b1;
            end else if (i_cmd.play_fire) begin
                r_parity <= 1'b0;
                if (r_play_ptr == IW'(TABLE_DEPTH - 1)) begin
                    r_play_ptr <= '0;
                end else begin
                    r_play_ptr <= r_play_ptr + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rnd  <= i_in.random_word;
            r_fire <= 1'b0;
            r_chan <= '0;
        end
        if (i_cmd.mul) begin
            r_quot <= prod[SHIFT +: RAND_W];
        end
        if (i_cmd.sub) begin
            r_slot <= rem[IW-1:0];
        end
        if (ram_re) begin
            r_rd_addr  <= ram_raddr;
            r_rd_valid <= r_valid[ram_raddr];
        end
        if (i_cmd.rd_r) begin
            r_val_a <= rd_data;
        end
        if (i_cmd.play_fire) begin
            r_fire <= 1'b1;
            r_chan <= rd_data;
        end
        if (i_cmd.load_out) begin
            r_out.fire         <= r_fire;
            r_out.channel      <= CHAN_W'(r_chan);
            r_out.shuffle_busy <= (r_swap_index != '0);
        end
    end

    assign o_status.swap_active = (r_swap_index != '0);
    assign o_status.parity      = r_parity;
    assign o_out                = r_out;

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_r |-> (r_slot <= r_swap_index))
        else $error("swap slot beyond the swap index");

    a_index_steps_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_r |=> (r_swap_index == $past(r_swap_index) - IW'(1)))
        else $error("swap index did not count down after a swap");

endmodule

// ===== design/shuffled_channel_sequencer_core.sv =====
// Shuffled channel sequencer top level: controller, datapath and ports.
// Steps from accept to result: start sets the swap index; a swap step walks multiply,
// remainder and read, read, write, write (none when no swap is pending); a trigger
// arms, or reads and fires; other codes complete at once. The next transaction is
// accepted the cycle after a result is loaded into the output register, one at a time;
// a swap step holds the reciprocal and remainder multiplies and four table accesses.
// Reset (synchronous, active low) clears control, sets shuffle_size to 16 and marks every
// table entry unwritten so it reads as its identity value; no clearing pass is needed.
module shuffled_channel_sequencer_core
    import scs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out,
    // shuffle_size register
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

    // Command and status between the state machine and the datapath.
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // The controller sequences one transaction at a time: accept in idle, walk the
    // multiply, remainder-and-read, read, write, write steps for a swap, a read for a
    // firing trigger, then hold in the completion state until the output register
    // is free.
    scs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in.cmd),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath owns the order table RAM, the swap index, the play pointer, the pulse
    // parity and result register; it acts on controller commands and shuffle_size writes.
    scs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out       (o_out)
    );

endmodule
